@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on every rising edge outside reset.
`define LBO_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("layer blend assertion failed");
// Same-cycle implication.
`define LBO_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("layer blend implication failed");
`else
`define LBO_ASSERT(lbl, clk, rst_n, prop)
`define LBO_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/core/lbo_pkg.sv @@
package lbo_pkg;

	typedef logic [7:0]  chan_t;
	typedef chan_t [2:0] rgb_t;   // [0] red, [1] green, [2] blue
	typedef logic [14:0] mix_t;   // p*v + (100-p)*b, at most 25500

	// blend mode codes
	localparam logic [2:0] MODE_AVG      = 3'd1;
	localparam logic [2:0] MODE_MULTIPLY = 3'd2;
	localparam logic [2:0] MODE_DARKEN   = 3'd3;
	localparam logic [2:0] MODE_LIGHTEN  = 3'd4;
	localparam logic [2:0] MODE_SCREEN   = 3'd5;

	// register indexes
	localparam logic REG_MODE    = 1'b0;
	localparam logic REG_OPACITY = 1'b1;

	localparam logic [2:0] MODE_RESET    = MODE_AVG;
	localparam logic [6:0] OPACITY_RESET = 7'd0;
	localparam logic [6:0] PCT_FULL      = 7'd100;

	// floor(x/100) == (x*5243) >> 19 for all x <= 25500
	localparam logic [12:0] DIV100_MUL   = 13'd5243;
	localparam int          DIV100_SHIFT = 19;

	typedef struct packed {
		logic [2:0] mode;
		logic [6:0] opacity;
	} blend_cfg_t;

endpackage

@@ rtl/core/lbo_blend.sv @@
module lbo_blend
	import lbo_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  blend_cfg_t cfg,
	input  logic       up_valid,
	output logic       up_ready,
	input  rgb_t       bg,
	input  rgb_t       fg,
	output logic       dn_valid,
	input  logic       dn_ready,
	output rgb_t       blend_s1,
	output rgb_t       bg_s1,
	output logic [6:0] pct_s1,
	output logic       wr_s1
);

	logic       vld_s1;
	logic       mode_ok;
	logic [6:0] pct;
	rgb_t       blend;

	assign up_ready = !vld_s1 || dn_ready;
	assign dn_valid = vld_s1;
	assign pct      = (cfg.opacity > PCT_FULL) ? PCT_FULL : cfg.opacity;

	always_comb begin
		mode_ok = 1'b0;
		unique case (cfg.mode) inside
			MODE_AVG, MODE_MULTIPLY, MODE_DARKEN, MODE_LIGHTEN, MODE_SCREEN: mode_ok = 1'b1;
			default: mode_ok = 1'b0;
		endcase
	end

	for (genvar c = 0; c < 3; c++) begin : g_chan
		logic [8:0]  sum;
		logic [15:0] prod;
		logic [7:0]  inv_f;
		logic [7:0]  inv_b;
		logic [15:0] inv_prod;

		assign sum      = {1'b0, fg[c]} + {1'b0, bg[c]};
		assign prod     = fg[c] * bg[c];
		assign inv_f    = ~fg[c];   // 255 - f
		assign inv_b    = ~bg[c];   // 255 - b
		assign inv_prod = inv_f * inv_b;

		always_comb begin
			unique case (cfg.mode)
				MODE_AVG:      blend[c] = sum[8:1];
				MODE_MULTIPLY: blend[c] = prod[15:8];
				MODE_DARKEN:   blend[c] = (fg[c] < bg[c]) ? fg[c] : bg[c];
				MODE_LIGHTEN:  blend[c] = (fg[c] > bg[c]) ? fg[c] : bg[c];
				MODE_SCREEN:   blend[c] = ~inv_prod[15:8];   // 255 - x
				default:       blend[c] = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (up_ready) begin
			vld_s1 <= up_valid;
		end
	end

	// unused mode: zero every operand so the result comes out zero
	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			blend_s1 <= blend;
			bg_s1    <= mode_ok ? bg : '0;
			pct_s1   <= mode_ok ? pct : '0;
			wr_s1    <= mode_ok;
		end
	end

endmodule

@@ rtl/core/lbo_mix.sv @@
module lbo_mix
	import lbo_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       up_valid,
	output logic       up_ready,
	input  rgb_t       blend_s1,
	input  rgb_t       bg_s1,
	input  logic [6:0] pct_s1,
	input  logic       wr_s1,
	output logic       dn_valid,
	input  logic       dn_ready,
	output mix_t [2:0] sum_s2,
	output logic       wr_s2
);

	logic       vld_s2;
	logic [6:0] pct_inv;
	mix_t [2:0] sum;

	assign up_ready = !vld_s2 || dn_ready;
	assign dn_valid = vld_s2;
	assign pct_inv  = PCT_FULL - pct_s1;

	for (genvar c = 0; c < 3; c++) begin : g_chan
		mix_t term_v;
		mix_t term_b;
		assign term_v = pct_s1 * blend_s1[c];
		assign term_b = pct_inv * bg_s1[c];
		assign sum[c] = term_v + term_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (up_ready) begin
			vld_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			sum_s2 <= sum;
			wr_s2  <= wr_s1;
		end
	end

endmodule

@@ rtl/core/lbo_div.sv @@
module lbo_div
	import lbo_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       up_valid,
	output logic       up_ready,
	input  mix_t [2:0] sum_s2,
	input  logic       wr_s2,
	output logic       dn_valid,
	input  logic       dn_ready,
	output rgb_t       pix_s3,
	output logic       wr_s3
);

	logic vld_s3;
	rgb_t quot;

	assign up_ready = !vld_s3 || dn_ready;
	assign dn_valid = vld_s3;

	// divide by 100 through a reciprocal multiply
	for (genvar c = 0; c < 3; c++) begin : g_chan
		logic [27:0] prod;
		assign prod    = sum_s2[c] * DIV100_MUL;
		assign quot[c] = prod[DIV100_SHIFT +: 8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (up_ready) begin
			vld_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			pix_s3 <= quot;
			wr_s3  <= wr_s2;
		end
	end

endmodule

@@ rtl/core/layer_blend_with_opacity.sv @@
// Channel  Handshake              Payload
// pixel    pix_valid / pix_stall  bg_red bg_green bg_blue fg_red fg_green fg_blue
// result   res_valid / res_stall  out_red out_green out_blue written
// config   cfg_valid / cfg_ready  cfg_index (0 mode, 1 opacity), cfg_data
//
// Three register stages (blend, weighted sum, /100): a pixel taken into the
// blend register moves on to the weighted-sum register and then to the /100
// output register; one pixel per cycle sustained while res_stall stays low.
// Each stage takes new data when empty or when its contents move on, so
// bubbles close up and a stall on the result side backs up stage by stage.
// Reset (arst_n low) empties the pipe, mode returns to average, opacity to 0.
// Config writes are always taken (cfg_ready high).
`include "assert_macros.svh"

module layer_blend_with_opacity
	import lbo_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [6:0] cfg_data,
	// pixel in
	input  logic       pix_valid,
	output logic       pix_stall,
	input  logic [7:0] bg_red,
	input  logic [7:0] bg_green,
	input  logic [7:0] bg_blue,
	input  logic [7:0] fg_red,
	input  logic [7:0] fg_green,
	input  logic [7:0] fg_blue,
	// result out
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] out_red,
	output logic [7:0] out_green,
	output logic [7:0] out_blue,
	output logic       written
);

	// configuration registers
	blend_cfg_t cfg_q;

	// stage links
	logic       s1_ready, s1_valid;
	rgb_t       blend_s1, bg_s1;
	logic [6:0] pct_s1;
	logic       wr_s1;
	logic       s2_ready, s2_valid;
	mix_t [2:0] sum_s2;
	logic       wr_s2;
	logic       s3_ready;
	rgb_t       pix_s3;
	logic       wr_s3;
	rgb_t       bg, fg;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode    <= MODE_RESET;
			cfg_q.opacity <= OPACITY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MODE:    cfg_q.mode    <= cfg_data[2:0];
				REG_OPACITY: cfg_q.opacity <= cfg_data;
				default:     ;
			endcase
		end
	end

	assign bg = {bg_blue, bg_green, bg_red};
	assign fg = {fg_blue, fg_green, fg_red};

	assign pix_stall = !s1_ready;

	// stage 1: per-channel blend, mode decode, opacity clamp
	lbo_blend u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.up_valid (pix_valid),
		.up_ready (s1_ready),
		.bg       (bg),
		.fg       (fg),
		.dn_valid (s1_valid),
		.dn_ready (s2_ready),
		.blend_s1 (blend_s1),
		.bg_s1    (bg_s1),
		.pct_s1   (pct_s1),
		.wr_s1    (wr_s1)
	);

	// stage 2: p*v + (100-p)*b
	lbo_mix u_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (s1_valid),
		.up_ready (s2_ready),
		.blend_s1 (blend_s1),
		.bg_s1    (bg_s1),
		.pct_s1   (pct_s1),
		.wr_s1    (wr_s1),
		.dn_valid (s2_valid),
		.dn_ready (s3_ready),
		.sum_s2   (sum_s2),
		.wr_s2    (wr_s2)
	);

	// stage 3: floor divide by 100; this register is the output
	lbo_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (s2_valid),
		.up_ready (s3_ready),
		.sum_s2   (sum_s2),
		.wr_s2    (wr_s2),
		.dn_valid (res_valid),
		.dn_ready (!res_stall),
		.pix_s3   (pix_s3),
		.wr_s3    (wr_s3)
	);

	assign out_red   = pix_s3[0];
	assign out_green = pix_s3[1];
	assign out_blue  = pix_s3[2];
	assign written   = wr_s3;

	// a pixel that is not written comes out black
	`LBO_ASSERT_IMP(a_unwritten_zero, clk, arst_n, res_valid && !written,
		out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0)
	// with the output stage empty the whole pipe can take a transaction
	`LBO_ASSERT_IMP(a_empty_no_stall, clk, arst_n, !res_valid, !pix_stall)
	// a fresh result only ever comes from a filled stage 2
	`LBO_ASSERT(a_result_from_s2, clk, arst_n, $rose(res_valid) |-> $past(s2_valid))

endmodule

@@ tb/layer_blend_with_opacity_tb.sv @@
module layer_blend_with_opacity_tb;
	import lbo_pkg::*;

	// Mode codes with no blend behind them: the pixel is not written
	localparam logic [2:0] MODE_UNUSED_0 = 3'd0;
	localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
	localparam logic [2:0] MODE_UNUSED_7 = 3'd7;

	localparam logic [6:0] OPACITY_TOP = 7'd127;
	localparam int RANDOM_ITEMS = 1300;
	// Run limit; keep a wide margin over the slowest legal run
	localparam int CYCLE_LIMIT = 400000;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURSTY} stall_style_e;

	typedef struct packed {
		rgb_t pix;
		logic written;
	} blend_res_t;

	// Expected-pixel store with its own copy of the two registers
	class blend_scoreboard;
		logic [2:0] mode;
		logic [6:0] opacity;
		blend_res_t expected_q[$];
		int error_count;

		function new();
			mode = MODE_RESET;
			opacity = OPACITY_RESET;
			error_count = 0;
		endfunction

		function void write_reg(logic idx, logic [6:0] data);
			if (idx == REG_MODE)
				mode = data[2:0];
			else
				opacity = data;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function chan_t blend_chan(chan_t f, chan_t b);
			int unsigned fv, bv, v, p, m;
			fv = f;
			bv = b;
			case (mode)
				MODE_AVG:      v = (fv + bv) >> 1;
				MODE_MULTIPLY: v = (fv * bv) >> 8;
				MODE_DARKEN:   v = (fv < bv) ? fv : bv;
				MODE_LIGHTEN:  v = (fv > bv) ? fv : bv;
				MODE_SCREEN:   v = 255 - (((255 - fv) * (255 - bv)) >> 8);
				default:       v = 0;
			endcase
			p = (opacity > PCT_FULL) ? PCT_FULL : opacity;
			m = (p * v + (PCT_FULL - p) * bv) / PCT_FULL;
			return m[7:0];
		endfunction

		function void note_pixel(rgb_t bg, rgb_t fg);
			blend_res_t r;
			r = '0;
			if (mode inside {MODE_AVG, MODE_MULTIPLY, MODE_DARKEN, MODE_LIGHTEN,
					MODE_SCREEN}) begin
				for (int c = 0; c < 3; c++)
					r.pix[c] = blend_chan(fg[c], bg[c]);
				r.written = 1'b1;
			end
			expected_q.push_back(r);
		endfunction

		task report_mismatch(string what, int got, int want);
			$display("t=%0t %s: got %0d, expected %0d", $time, what, got, want);
			error_count++;
		endtask

		task check_result(rgb_t got, logic got_written);
			blend_res_t want;
			if (expected_q.size() == 0) begin
				report_mismatch("result with nothing pending", got, 0);
				return;
			end
			want = expected_q.pop_front();
			if (got[0] !== want.pix[0]) report_mismatch("out_red", got[0], want.pix[0]);
			if (got[1] !== want.pix[1]) report_mismatch("out_green", got[1], want.pix[1]);
			if (got[2] !== want.pix[2]) report_mismatch("out_blue", got[2], want.pix[2]);
			if (got_written !== want.written)
				report_mismatch("written", got_written, want.written);
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic       cfg_index;
	logic [6:0] cfg_data;
	logic       pix_valid;
	logic       pix_stall;
	logic [7:0] bg_red, bg_green, bg_blue;
	logic [7:0] fg_red, fg_green, fg_blue;
	logic       res_valid;
	logic       res_stall;
	logic [7:0] out_red, out_green, out_blue;
	logic       written;

	blend_scoreboard sb;
	int cycle_count;
	int items_sent;

	// receiver stall pattern state, owned by the stall process
	stall_style_e stall_style;
	int stall_left;
	int stall_phase;
	int stall_period;

	layer_blend_with_opacity u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.bg_red    (bg_red),
		.bg_green  (bg_green),
		.bg_blue   (bg_blue),
		.fg_red    (fg_red),
		.fg_green  (fg_green),
		.fg_blue   (fg_blue),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue),
		.written   (written)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run guard: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Monitors. Everything the bench drives moves on the falling edge, so at
	// the rising edge both sides are settled and the DUT's own register
	// updates have not yet landed.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (pix_valid && !pix_stall)
				sb.note_pixel({bg_blue, bg_green, bg_red}, {fg_blue, fg_green, fg_red});
			if (res_valid && !res_stall)
				sb.check_result({out_blue, out_green, out_red}, written);
		end
	end

	// Receiver back-pressure: a style is held for a random stretch, including
	// stretches with no stalling at all, then another is picked.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_style = stall_style_e'($urandom_range(0, 3));
			stall_left = $urandom_range(30, 200);
			stall_period = $urandom_range(2, 12);
			stall_phase = 0;
		end
		stall_left--;
		stall_phase = (stall_phase + 1) % stall_period;
		case (stall_style)
			STALL_NONE:   res_stall <= 1'b0;
			STALL_LIGHT:  res_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY:  res_stall <= ($urandom_range(0, 3) != 0);
			STALL_BURSTY: res_stall <= (stall_phase < stall_period / 2);
		endcase
	end

	function automatic rgb_t rgb(chan_t r, chan_t g, chan_t b);
		return {b, g, r};
	endfunction

	// Random channel, pulled to the rails now and then
	function automatic chan_t rand_chan();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return 8'($urandom_range(0, 255));
	endfunction

	// Register write transaction; called on a falling edge, returns on one
	// with valid still high so that writes can follow back to back
	task write_reg(logic idx, logic [6:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// Mode register only keeps the low three bits; junk above them is sent on purpose
	task set_blend(logic [2:0] mode, logic [6:0] opacity);
		if ($urandom_range(0, 1)) begin
			write_reg(REG_MODE, {4'($urandom_range(0, 15)), mode});
			write_reg(REG_OPACITY, opacity);
		end else begin
			write_reg(REG_OPACITY, opacity);
			write_reg(REG_MODE, {4'($urandom_range(0, 15)), mode});
		end
		cfg_valid <= 1'b0;
	endtask

	// One pixel transaction. Valid stays up on return so that a burst runs
	// back to back; the payload is held while stalled.
	task send_pixel(rgb_t bg, rgb_t fg);
		pix_valid <= 1'b1;
		{bg_blue, bg_green, bg_red} <= bg;
		{fg_blue, fg_green, fg_red} <= fg;
		do @(posedge clk); while (pix_stall);
		@(negedge clk);
		items_sent++;
	endtask

	task pixel_gap(int n);
		if (n > 0) begin
			pix_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// Sender holds off until every pending pixel has come back
	task drain();
		pix_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task directed_item(rgb_t bg, rgb_t fg);
		send_pixel(bg, fg);
		pixel_gap($urandom_range(0, 2));
	endtask

	// Bursty random traffic for one register setting
	task random_phase(int n);
		int left, burst;
		left = n;
		while (left > 0) begin
			burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
			if (burst > left) burst = left;
			repeat (burst)
				send_pixel(rgb(rand_chan(), rand_chan(), rand_chan()),
					rgb(rand_chan(), rand_chan(), rand_chan()));
			left -= burst;
			pixel_gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
		end
	endtask

	initial begin
		logic [2:0] valid_modes[5];
		logic [2:0] unused_modes[3];
		logic [2:0] mode;
		logic [6:0] opacity;
		rgb_t lo_hi, hi_lo;

		valid_modes = '{MODE_AVG, MODE_MULTIPLY, MODE_DARKEN, MODE_LIGHTEN, MODE_SCREEN};
		unused_modes = '{MODE_UNUSED_0, MODE_UNUSED_6, MODE_UNUSED_7};
		sb = new();
		cycle_count = 0;
		items_sent = 0;
		stall_left = 0;
		stall_phase = 0;
		stall_period = 2;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_MODE;
		cfg_data = '0;
		pix_valid = 1'b0;
		res_stall = 1'b0;
		{bg_red, bg_green, bg_blue} = '0;
		{fg_red, fg_green, fg_blue} = '0;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed ---
		lo_hi = rgb(8'h00, 8'hFF, 8'h80);
		hi_lo = rgb(8'hFF, 8'h00, 8'h7F);

		// Reset settings: average at zero opacity, so the background passes through
		directed_item(rgb(8'h00, 8'h00, 8'h00), rgb(8'h00, 8'h00, 8'h00));
		directed_item(rgb(8'hFF, 8'hFF, 8'hFF), rgb(8'hFF, 8'hFF, 8'hFF));
		directed_item(lo_hi, hi_lo);
		directed_item(hi_lo, lo_hi);
		drain();

		// Every blend at full opacity, rails on the red and green channels
		foreach (valid_modes[i]) begin
			set_blend(valid_modes[i], PCT_FULL);
			directed_item(lo_hi, hi_lo);
			directed_item(rgb(8'hFF, 8'hFF, 8'h01), rgb(8'hFF, 8'h00, 8'hFE));
			drain();
		end

		// Modes without a blend: nothing written, outputs zero
		foreach (unused_modes[i]) begin
			set_blend(unused_modes[i], 7'd50);
			directed_item(hi_lo, lo_hi);
			drain();
		end

		// Opacity above full saturates to full
		set_blend(MODE_SCREEN, OPACITY_TOP);
		directed_item(lo_hi, rgb(8'h10, 8'hC0, 8'h55));
		drain();
		set_blend(MODE_MULTIPLY, 7'd101);
		directed_item(rgb(8'hC8, 8'h37, 8'hFF), rgb(8'hFF, 8'h99, 8'h02));
		drain();

		// Bottom of the opacity range
		set_blend(MODE_DARKEN, 7'd0);
		directed_item(hi_lo, lo_hi);
		drain();
		set_blend(MODE_LIGHTEN, 7'd1);
		directed_item(lo_hi, hi_lo);
		drain();

		// --- random ---
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 6) == 0)
				mode = unused_modes[2'($urandom_range(0, 2))];
			else
				mode = valid_modes[3'($urandom_range(0, 4))];
			case ($urandom_range(0, 5))
				0:       opacity = 7'd0;
				1:       opacity = PCT_FULL;
				2:       opacity = OPACITY_TOP;
				3:       opacity = 7'($urandom_range(101, 127));
				default: opacity = 7'($urandom_range(0, 100));
			endcase
			set_blend(mode, opacity);
			random_phase($urandom_range(40, 160));
			drain();
		end

		// pipe is three deep; a little slack for stragglers
		repeat (10) @(posedge clk);
		if (sb.error_count == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
